// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the timer bank sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define CPTB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property violated");
// expression must never be true outside reset
`define CPTB_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define CPTB_ASSERT(label, clk, rst_n, prop)
`define CPTB_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== hw/rtl/cptb_pkg.sv =====
// types, constants and helpers for the cascaded prescaled timer bank
package cptb_pkg;

    localparam int MAX_TIMERS      = 4;
    localparam int IDX_W           = 2;
    localparam int CMD_W           = 2;
    localparam int OFF_W           = 4;
    localparam int BYTE_W          = 8;
    localparam int CYC_W           = 5;
    localparam int CNT_W           = 16;
    localparam int ACC_W           = 11;
    localparam int IRQ_W           = 4;
    localparam int MAX_STEP_CYCLES = 16;
    localparam int DEF_NUM_TIMERS  = 4;

    localparam int PERIOD_DIV1    = 1;
    localparam int PERIOD_DIV64   = 64;
    localparam int PERIOD_DIV256  = 256;
    localparam int PERIOD_DIV1024 = 1024;

    // control register bit positions
    localparam int CTRL_CASCADE_BIT = 2;
    localparam int CTRL_IRQ_BIT     = 6;
    localparam int CTRL_RUN_BIT     = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADVANCE = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_READ    = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        BYTE_LOW  = 2'd0,
        BYTE_HIGH = 2'd1,
        BYTE_CTRL = 2'd2,
        BYTE_NONE = 2'd3
    } byte_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_CHECK,
        ST_TICK,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic             capture;
        logic             reg_write;
        logic             reg_read;
        logic             acc_load;
        logic             acc_sub;
        logic             acc_store;
        logic             tick;
        logic             out_load;
        logic [IDX_W-1:0] tidx;
    } cptb_cmd_t;

    // datapath to controller
    typedef struct packed {
        cmd_t             item_cmd;
        logic [IDX_W-1:0] item_tidx;
        logic             eligible;
        logic             acc_ge;
        logic             wrap;
        logic             chain_next;
    } cptb_status_t;

    function automatic logic [ACC_W-1:0] period_of(input logic [1:0] sel);
        logic [ACC_W-1:0] per;
        case (sel)
            2'd0:    per = ACC_W'(PERIOD_DIV1);
            2'd1:    per = ACC_W'(PERIOD_DIV64);
            2'd2:    per = ACC_W'(PERIOD_DIV256);
            default: per = ACC_W'(PERIOD_DIV1024);
        endcase
        return per;
    endfunction

endpackage

// ===== hw/rtl/cascaded_prescaled_timer_bank_top.sv =====
// top level of the cascaded prescaled timer bank
// Bank of NUM_TIMERS 16-bit up-counting timers behind byte registers, one result
// word per input word. The input word carries the command in tuser (advance,
// write byte, read byte) and offset, write data and cycle count in tdata; the
// result word returns the read byte and the interrupt bits raised during that
// word. Words are handled one at a time by a sequencer. A read, a write or an
// unknown command goes from capture through execute to finish. An advance
// instead scans the timers in turn, checks the prescaler of each running timer
// that counts from its prescaler, ticks it once for each full prescaler period,
// and walks the cascade chain on each cascaded overflow; the tick loop dominates.
// A new word is accepted while the previous result waits in the output register.
module cascaded_prescaled_timer_bank_top #(
    parameter int NUM_TIMERS = cptb_pkg::DEF_NUM_TIMERS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // reg_offset [3:0], write_byte [11:4], cycle_count [16:12], zero fill
    input  logic [23:0] s_axis_tdata,
    // command [1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_byte [7:0], irq_request [11:8], zero fill
    output logic [15:0] m_axis_tdata
);
    import cptb_pkg::*;

    cptb_cmd_t         cmd;
    cptb_status_t      status;
    logic [BYTE_W-1:0] read_byte;
    logic [IRQ_W-1:0]  irq_request;

    // sequencer: dispatch, prescaler scan, cascade walk
    cptb_ctrl #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    // timer registers and result path
    cptb_datapath #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .in_command      (s_axis_tuser),
        .in_reg_offset   (s_axis_tdata[3:0]),
        .in_write_byte   (s_axis_tdata[11:4]),
        .in_cycle_count  (s_axis_tdata[16:12]),
        .out_read_byte   (read_byte),
        .out_irq_request (irq_request)
    );

    assign m_axis_tdata = {4'b0000, irq_request, read_byte};

endmodule

// ===== hw/rtl/cptb_datapath.sv =====
// timer state, prescaler accumulators and result registers
module cptb_datapath #(
    parameter int NUM_TIMERS = cptb_pkg::DEF_NUM_TIMERS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cptb_pkg::cptb_cmd_t       cmd,
    output cptb_pkg::cptb_status_t    status,
    input  logic [cptb_pkg::CMD_W-1:0]  in_command,
    input  logic [cptb_pkg::OFF_W-1:0]  in_reg_offset,
    input  logic [cptb_pkg::BYTE_W-1:0] in_write_byte,
    input  logic [cptb_pkg::CYC_W-1:0]  in_cycle_count,
    output logic [cptb_pkg::BYTE_W-1:0] out_read_byte,
    output logic [cptb_pkg::IRQ_W-1:0]  out_irq_request
);
    import cptb_pkg::*;

    localparam int TIDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    logic [CMD_W-1:0]  item_cmd_reg;
    logic [OFF_W-1:0]  item_off_reg;
    logic [BYTE_W-1:0] item_data_reg;
    logic [CYC_W-1:0]  item_cyc_reg;

    logic [CNT_W-1:0] count_reg  [NUM_TIMERS];
    logic [CNT_W-1:0] reload_reg [NUM_TIMERS];
    logic [1:0]       div_sel_reg[NUM_TIMERS];
    logic [ACC_W-1:0] acc_reg    [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] cascade_reg;
    logic [NUM_TIMERS-1:0] irq_en_reg;
    logic [NUM_TIMERS-1:0] running_reg;

    logic [ACC_W-1:0]      acc_work_reg;
    logic [NUM_TIMERS-1:0] irq_reg;
    logic [BYTE_W-1:0]     rd_reg;
    logic [BYTE_W-1:0]     out_rd_reg;
    logic [IRQ_W-1:0]      out_irq_reg;

    logic [TIDX_W-1:0]     idx;
    logic [NUM_TIMERS-1:0] cascade_next;
    logic [ACC_W-1:0]      cyc_sat;
    logic [ACC_W-1:0]      period;
    logic [CNT_W-1:0]      count_inc;
    logic                  item_ok;
    byte_sel_t             item_byte;
    logic [BYTE_W-1:0]     ctrl_byte;
    logic [BYTE_W-1:0]     rd_value;

    assign idx       = cmd.tidx[TIDX_W-1:0];
    assign item_byte = byte_sel_t'(item_off_reg[1:0]);
    assign item_ok   = ({1'b0, item_off_reg[OFF_W-1:2]} < 3'(NUM_TIMERS));
    assign period    = period_of(div_sel_reg[idx]);
    assign count_inc = count_reg[idx] + CNT_W'(1);

    // saturate the step length
    assign cyc_sat = (ACC_W'(item_cyc_reg) > ACC_W'(MAX_STEP_CYCLES))
                   ? ACC_W'(MAX_STEP_CYCLES) : ACC_W'(item_cyc_reg);

    // bit i: timer i+1 exists and runs in cascade mode
    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_casc
        if (g + 1 < NUM_TIMERS) begin : g_has_next
            assign cascade_next[g] = cascade_reg[g+1] & running_reg[g+1];
        end else begin : g_last
            assign cascade_next[g] = 1'b0;
        end
    end

    assign ctrl_byte = {running_reg[idx], irq_en_reg[idx], 3'b000,
                        cascade_reg[idx], div_sel_reg[idx]};

    always_comb
    begin
        rd_value = '0;
        if (item_ok)
        begin
            case (item_byte)
                BYTE_LOW:  rd_value = count_reg[idx][7:0];
                BYTE_HIGH: rd_value = count_reg[idx][15:8];
                BYTE_CTRL: rd_value = ctrl_byte;
                default:   rd_value = '0;
            endcase
        end
    end

    assign status.item_cmd   = cmd_t'(item_cmd_reg);
    assign status.item_tidx  = item_off_reg[OFF_W-1:2];
    assign status.eligible   = running_reg[idx] & ((idx == '0) | ~cascade_reg[idx]);
    assign status.acc_ge     = (acc_work_reg >= period);
    assign status.wrap       = (count_reg[idx] == '1);
    assign status.chain_next = cascade_next[idx];

    // item capture and per-item result
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_cmd_reg  <= in_command;
            item_off_reg  <= in_reg_offset;
            item_data_reg <= in_write_byte;
            item_cyc_reg  <= in_cycle_count;
        end
        if (cmd.acc_load)
            acc_work_reg <= acc_reg[idx] + cyc_sat;
        else if (cmd.acc_sub)
            acc_work_reg <= acc_work_reg - period;
        if (cmd.capture)
            rd_reg <= '0;
        else if (cmd.reg_read)
            rd_reg <= rd_value;
        if (cmd.out_load)
        begin
            out_rd_reg  <= rd_reg;
            out_irq_reg <= IRQ_W'(irq_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            irq_reg     <= '0;
            cascade_reg <= '0;
            irq_en_reg  <= '0;
            running_reg <= '0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                count_reg[i]   <= '0;
                reload_reg[i]  <= '0;
                div_sel_reg[i] <= '0;
                acc_reg[i]     <= '0;
            end
        end
        else
        begin
            if (cmd.capture)
                irq_reg <= '0;
            else if (cmd.tick && status.wrap && irq_en_reg[idx])
                irq_reg[idx] <= 1'b1;

            if (cmd.tick)
                count_reg[idx] <= status.wrap ? reload_reg[idx] : count_inc;

            if (cmd.acc_store)
                acc_reg[idx] <= acc_work_reg;

            if (cmd.reg_write && item_ok)
            begin
                case (item_byte)
                    BYTE_LOW:  reload_reg[idx][7:0]  <= item_data_reg;
                    BYTE_HIGH: reload_reg[idx][15:8] <= item_data_reg;
                    BYTE_CTRL:
                    begin
                        div_sel_reg[idx] <= item_data_reg[1:0];
                        cascade_reg[idx] <= item_data_reg[CTRL_CASCADE_BIT];
                        irq_en_reg[idx]  <= item_data_reg[CTRL_IRQ_BIT];
                        running_reg[idx] <= item_data_reg[CTRL_RUN_BIT];
                        acc_reg[idx]     <= '0;
                        // start edge reloads the counter
                        if (!running_reg[idx] && item_data_reg[CTRL_RUN_BIT])
                            count_reg[idx] <= reload_reg[idx];
                    end
                    default: ;
                endcase
            end
        end
    end

    assign out_read_byte   = out_rd_reg;
    assign out_irq_request = out_irq_reg;

endmodule

// ===== hw/rtl/cptb_ctrl.sv =====
// sequencer for item dispatch, prescaler scan and cascade ticks
`include "assert_macros.svh"
module cptb_ctrl #(
    parameter int NUM_TIMERS = cptb_pkg::DEF_NUM_TIMERS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output cptb_pkg::cptb_cmd_t    cmd,
    input  cptb_pkg::cptb_status_t status
);
    import cptb_pkg::*;

    localparam int TIDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [TIDX_W-1:0] LAST = TIDX_W'(NUM_TIMERS - 1);

    state_t            state_reg, state_next;
    logic [TIDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic [TIDX_W-1:0] chain_idx_reg, chain_idx_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // next state and index counters
    always_comb
    begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        chain_idx_next = chain_idx_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_EXEC;
            ST_EXEC:
                if (status.item_cmd == CMD_ADVANCE)
                begin
                    state_next    = ST_SCAN;
                    scan_idx_next = '0;
                end
                else
                    state_next = ST_FINISH;
            ST_SCAN:
                if (status.eligible)
                    state_next = ST_CHECK;
                else if (scan_idx_reg == LAST)
                    state_next = ST_FINISH;
                else
                    scan_idx_next = scan_idx_reg + TIDX_W'(1);
            ST_CHECK:
                if (status.acc_ge)
                begin
                    state_next     = ST_TICK;
                    chain_idx_next = scan_idx_reg;
                end
                else if (scan_idx_reg == LAST)
                    state_next = ST_FINISH;
                else
                begin
                    state_next    = ST_SCAN;
                    scan_idx_next = scan_idx_reg + TIDX_W'(1);
                end
            ST_TICK:
                if (status.wrap && status.chain_next)
                    chain_idx_next = chain_idx_reg + TIDX_W'(1);
                else
                    state_next = ST_CHECK;
            ST_FINISH:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd           = '0;
        cmd.capture   = (state_reg == ST_IDLE) && in_valid;
        cmd.tidx      = IDX_W'(scan_idx_reg);
        case (state_reg)
            ST_EXEC:
            begin
                cmd.tidx      = status.item_tidx;
                cmd.reg_write = (status.item_cmd == CMD_WRITE);
                cmd.reg_read  = (status.item_cmd == CMD_READ);
            end
            ST_SCAN:
                cmd.acc_load = status.eligible;
            ST_CHECK:
            begin
                cmd.acc_sub   = status.acc_ge;
                cmd.acc_store = !status.acc_ge;
            end
            ST_TICK:
            begin
                cmd.tidx = IDX_W'(chain_idx_reg);
                cmd.tick = 1'b1;
            end
            ST_FINISH:
                cmd.out_load = out_free;
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_idx_reg  <= '0;
            chain_idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            chain_idx_reg <= chain_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a pending result is never overwritten
    `CPTB_NEVER(a_no_overwrite, clk, rst_n, cmd.out_load && out_valid_reg && !out_ready)
    // a cascaded overflow moves the tick to the next timer
    `CPTB_ASSERT(a_chain_step, clk, rst_n,
        (state_reg == ST_TICK && status.wrap && status.chain_next) |=>
        (state_reg == ST_TICK && chain_idx_reg == $past(chain_idx_reg) + TIDX_W'(1)))
    // scan and chain stay inside the bank
    `CPTB_NEVER(a_idx_range, clk, rst_n, scan_idx_reg > LAST || chain_idx_reg > LAST)
    // a result leaves only when taken
    `CPTB_ASSERT(a_out_drop, clk, rst_n, $fell(out_valid_reg) |-> $past(out_ready))

endmodule

// ===== sim/timer_bank_checker.sv =====
// checker for the timer bank: watches both stream channels, predicts each result word and compares
`timescale 1ns / 1ps

module timer_bank_checker #(
    parameter int NUM_TIMERS = cptb_pkg::DEF_NUM_TIMERS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // reg_offset [3:0], write_byte [11:4], cycle_count [16:12], zero fill
    input  logic [23:0] s_axis_tdata,
    // command [1:0]
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_byte [7:0], irq_request [11:8], zero fill
    input  logic [15:0] m_axis_tdata,
    output int          fail_count,
    output int          awaited
);
    import cptb_pkg::*;

    typedef struct packed {
        logic [IRQ_W-1:0]  irq_request;
        logic [BYTE_W-1:0] read_byte;
    } timer_result_t;

    // mirrored timer state
    logic [CNT_W-1:0] count_q   [NUM_TIMERS];
    logic [CNT_W-1:0] reload_q  [NUM_TIMERS];
    logic [1:0]       div_sel_q [NUM_TIMERS];
    logic             cascade_q [NUM_TIMERS];
    logic             irq_en_q  [NUM_TIMERS];
    logic             run_q     [NUM_TIMERS];
    logic [ACC_W-1:0] accum_q   [NUM_TIMERS];

    timer_result_t due_results[$];

    // prescaler period: 1, 64, 256, 1024
    function automatic int prescale_period(input logic [1:0] sel);
        return (sel == 2'd0) ? 1 : (16 << (2 * sel));
    endfunction

    // one tick on timer first, carried along the cascade chain
    function automatic logic [IRQ_W-1:0] tick_with_carry(input int first);
        logic [IRQ_W-1:0] irq;
        int               t;
        bit               carry;
        irq   = '0;
        t     = first;
        carry = 1'b1;
        while (carry)
        begin
            carry      = 1'b0;
            count_q[t] = count_q[t] + 1'b1;
            if (count_q[t] == '0)
            begin
                count_q[t] = reload_q[t];
                if (irq_en_q[t])
                    irq[t] = 1'b1;
                if (t + 1 < NUM_TIMERS && cascade_q[t + 1] && run_q[t + 1])
                begin
                    t++;
                    carry = 1'b1;
                end
            end
        end
        return irq;
    endfunction

    function automatic timer_result_t predict_timer_step(input cmd_t cmd,
                                                        input logic [OFF_W-1:0] off,
                                                        input logic [BYTE_W-1:0] data,
                                                        input logic [CYC_W-1:0] cyc);
        timer_result_t r;
        int            t;
        byte_sel_t     bsel;
        int            steps;
        int            per;
        int            acc;
        logic          was_running;
        r     = '0;
        t     = off[3:2];
        bsel  = byte_sel_t'(off[1:0]);
        steps = (cyc > MAX_STEP_CYCLES) ? MAX_STEP_CYCLES : cyc;
        case (cmd)
            CMD_ADVANCE:
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    // timer 0 ignores its cascade bit
                    if (run_q[i] && (i == 0 || !cascade_q[i]))
                    begin
                        per = prescale_period(div_sel_q[i]);
                        acc = accum_q[i] + steps;
                        while (acc >= per)
                        begin
                            acc -= per;
                            r.irq_request |= tick_with_carry(i);
                        end
                        accum_q[i] = ACC_W'(acc);
                    end
                end
            end
            CMD_WRITE:
            begin
                if (t < NUM_TIMERS)
                begin
                    case (bsel)
                        BYTE_LOW:  reload_q[t][7:0]  = data;
                        BYTE_HIGH: reload_q[t][15:8] = data;
                        BYTE_CTRL:
                        begin
                            was_running  = run_q[t];
                            div_sel_q[t] = data[1:0];
                            cascade_q[t] = data[CTRL_CASCADE_BIT];
                            irq_en_q[t]  = data[CTRL_IRQ_BIT];
                            run_q[t]     = data[CTRL_RUN_BIT];
                            if (!was_running && run_q[t])
                                count_q[t] = reload_q[t];
                            accum_q[t] = '0;
                        end
                        default: ;
                    endcase
                end
            end
            CMD_READ:
            begin
                if (t < NUM_TIMERS)
                begin
                    case (bsel)
                        BYTE_LOW:  r.read_byte = count_q[t][7:0];
                        BYTE_HIGH: r.read_byte = count_q[t][15:8];
                        BYTE_CTRL: r.read_byte = {run_q[t], irq_en_q[t], 3'b000,
                                                  cascade_q[t], div_sel_q[t]};
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        timer_result_t seen;
        timer_result_t due;
        int            bad;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                count_q[i]   = '0;
                reload_q[i]  = '0;
                div_sel_q[i] = '0;
                cascade_q[i] = 1'b0;
                irq_en_q[i]  = 1'b0;
                run_q[i]     = 1'b0;
                accum_q[i]   = '0;
            end
            due_results.delete();
            fail_count <= 0;
            awaited    <= 0;
        end
        else
        begin
            bad = 0;
            // results first, so a word accepted this edge cannot match itself
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result word arrived with nothing predicted: %04h", m_axis_tdata);
                    bad++;
                end
                else
                begin
                    due  = due_results.pop_front();
                    seen = timer_result_t'(m_axis_tdata[11:0]);
                    if (seen.read_byte !== due.read_byte)
                    begin
                        $error("read_byte: expected %02h, got %02h", due.read_byte, seen.read_byte);
                        bad++;
                    end
                    if (seen.irq_request !== due.irq_request)
                    begin
                        $error("irq_request: expected %01h, got %01h",
                               due.irq_request, seen.irq_request);
                        bad++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                due_results.push_back(predict_timer_step(cmd_t'(s_axis_tuser),
                                                         s_axis_tdata[3:0],
                                                         s_axis_tdata[11:4],
                                                         s_axis_tdata[16:12]));
            fail_count <= fail_count + bad;
            awaited    <= due_results.size();
        end
    end

endmodule

// ===== sim/cascaded_prescaled_timer_bank_top_test.sv =====
// stimulus, handshake pacing and verdict for the cascaded prescaled timer bank
`timescale 1ns / 1ps

module cascaded_prescaled_timer_bank_top_test;
    import cptb_pkg::*;

    localparam int RANDOM_WORDS = 800;
    // no-progress limit: above the slowest advance and the long hold
    localparam int STALL_LIMIT  = 2000;
    // settle time after the last result, a bit above the slowest advance
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 100;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // reg_offset [3:0], write_byte [11:4], cycle_count [16:12], zero fill
    logic [23:0] s_axis_tdata;
    // command [1:0]
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // read_byte [7:0], irq_request [11:8], zero fill
    logic [15:0] m_axis_tdata;

    int fail_count;
    int awaited;
    int words_sent = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    bit hold_done = 1'b0;

    always #1 clk = ~clk;

    cascaded_prescaled_timer_bank_top #(
        .NUM_TIMERS(DEF_NUM_TIMERS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    timer_bank_checker #(
        .NUM_TIMERS(DEF_NUM_TIMERS)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .fail_count   (fail_count),
        .awaited      (awaited)
    );

    // offer one word and return at the edge that accepts it
    // the sender runs in bursts; a new burst may start after a random gap
    task automatic send_word(input cmd_t cmd, input logic [3:0] off,
                             input logic [7:0] data, input logic [4:0] cyc);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            // back-to-back bursts leave stretches with no gaps at all
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {7'b0, cyc, data, off};
        do
            @(posedge clk);
        while (!s_axis_tready);
        words_sent++;
    endtask

    // random word, biased so that counters sit near the top and overflow often
    task automatic send_random_word();
        int          roll;
        cmd_t        cmd;
        logic [3:0]  off;
        logic [7:0]  data;
        logic [4:0]  cyc;
        roll = $urandom_range(0, 99);
        off  = 4'($urandom_range(0, 15));
        data = 8'($urandom);
        cyc  = 5'($urandom_range(0, 31));
        if (roll < 45)
        begin
            cmd = CMD_ADVANCE;
            if ($urandom_range(0, 9) < 7)
                cyc = 5'($urandom_range(8, 16));
        end
        else if (roll < 80)
        begin
            cmd = CMD_WRITE;
            case (byte_sel_t'(off[1:0]))
                BYTE_HIGH:
                begin
                    // reload near 0xffff keeps overflows and cascades frequent
                    if ($urandom_range(0, 3) < 3)
                        data = 8'hFF;
                end
                BYTE_CTRL:
                begin
                    // favor divide-by-1 and running timers
                    if ($urandom_range(0, 1) == 1)
                        data[1:0] = 2'd0;
                    if ($urandom_range(0, 4) < 4)
                        data[CTRL_RUN_BIT] = 1'b1;
                end
                default: ;
            endcase
        end
        else if (roll < 95)
            cmd = CMD_READ;
        else
            cmd = CMD_NOP;
        send_word(cmd, off, data, cyc);
    endtask

    // main stimulus and verdict
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_ADVANCE;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values read back
        send_word(CMD_READ,  4'd2,  8'h00, 5'd0);
        send_word(CMD_READ,  4'd13, 8'h00, 5'd0);
        // reload write leaves the counter alone
        send_word(CMD_WRITE, 4'd0,  8'hFE, 5'd0);
        send_word(CMD_WRITE, 4'd1,  8'hFF, 5'd0);
        send_word(CMD_READ,  4'd0,  8'h00, 5'd0);
        // timer 1 cascades on timer 0, reload 0xffff so it overflows on every carry
        send_word(CMD_WRITE, 4'd4,  8'hFF, 5'd0);
        send_word(CMD_WRITE, 4'd5,  8'hFF, 5'd0);
        send_word(CMD_WRITE, 4'd6,  8'hC4, 5'd0);
        // start edge on timer 0 loads 0xfffe
        send_word(CMD_WRITE, 4'd2,  8'hC0, 5'd0);
        // timers 2 and 3 cascade too, last one carries into nothing
        send_word(CMD_WRITE, 4'd10, 8'h84, 5'd0);
        send_word(CMD_WRITE, 4'd15, 8'hFF, 5'd0);
        send_word(CMD_WRITE, 4'd14, 8'hC4, 5'd0);
        // full step, then an oversized step that saturates, then an empty one
        send_word(CMD_ADVANCE, 4'd0,  8'h00, 5'd16);
        send_word(CMD_ADVANCE, 4'd15, 8'hFF, 5'd31);
        send_word(CMD_ADVANCE, 4'd0,  8'h00, 5'd0);
        send_word(CMD_READ,  4'd6,  8'h00, 5'd0);
        send_word(CMD_READ,  4'd1,  8'h00, 5'd0);
        // unused byte: write dropped, read zero
        send_word(CMD_WRITE, 4'd3,  8'hAA, 5'd0);
        send_word(CMD_READ,  4'd3,  8'h00, 5'd0);
        // unknown command with every field set
        send_word(CMD_NOP,   4'd15, 8'hFF, 5'd31);
        // timer 0 with cascade bit and divide-by-1024: still counts from its prescaler,
        // rewrite while running clears the prescaler but does not reload
        send_word(CMD_WRITE, 4'd2,  8'h87, 5'd0);
        send_word(CMD_ADVANCE, 4'd0, 8'h00, 5'd16);
        send_word(CMD_READ,  4'd2,  8'h00, 5'd0);
        // stop timer 0 with divide-by-64
        send_word(CMD_WRITE, 4'd2,  8'h41, 5'd0);
        send_word(CMD_READ,  4'd2,  8'h00, 5'd0);

        repeat (RANDOM_WORDS) send_random_word();

        s_axis_tvalid <= 1'b0;
        // let the checker count the last accepted word before polling awaited
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver: stall pattern in segments, plus one long hold that backs up the input
    initial
    begin
        int mode;
        int seg_len;
        m_axis_tready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!hold_done && words_sent >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                mode    = $urandom_range(0, 2);
                seg_len = $urandom_range(8, 64);
                repeat (seg_len)
                begin
                    case (mode)
                        0:       m_axis_tready <= 1'b1;
                        1:       m_axis_tready <= 1'($urandom_range(0, 1));
                        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // watchdog: cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

endmodule
